### hw/rtl/rpn_pkg.sv
package rpn_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);

  // Q16.16 datapath
  localparam int unsigned Q_W    = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned DVD_W  = Q_W + FRAC_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W);

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(Q_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

  localparam logic [4:0]     MAX_PUSH_RST = 5'd16;
  localparam logic [Q_W-1:0] Q_MAX        = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN        = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_READ  = 3'd5,
    OP_CLEAR = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_DIVZ  = 3'd2,
    ST_MANY  = 3'd3,
    ST_LEFT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CALC,
    S_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN
  } alu_state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] res;
  } alu_rsp_t;

  // Apply sign to a magnitude and clamp to the Q16.16 range.
  function automatic logic [Q_W-1:0] sat_mag(input logic [DVD_W-1:0] m, input logic neg);
    logic [Q_W-1:0] r;
    if (neg) begin
      if (m > DVD_W'(Q_MIN)) r = Q_MIN;
      else r = Q_W'(0) - m[Q_W-1:0];
    end else begin
      if (m > DVD_W'(Q_MAX)) r = Q_MAX;
      else r = m[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/rpn_stack_calculator.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  op_i, operand_i
// out       output     out_valid_o / out_ready_i top_value_o, status_o, depth_o
// cfg       input      cfg_we_i (no wait)       cfg_wdata_i (max_pushes)
//
// One command at a time. Push, read, clear and a refused command go straight to the done
// state; divide by zero passes the load state first. Add and subtract use the ALU's
// saturating adder; multiply and divide use the shared 33-bit adder in rpn_alu, one bit per
// cycle (32 multiply steps, 48 divide steps).
// The next command is taken while a result still waits in the output register.
// Reset clears the stack level, the push count and the output valid; max_pushes is 16.
module rpn_stack_calculator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              op_i,
  input  logic signed [31:0]      operand_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [31:0]      top_value_o,
  output logic [2:0]              status_o,
  output logic [4:0]              depth_o,
  input  logic                    cfg_we_i,
  input  logic [4:0]              cfg_wdata_i
);
  import rpn_pkg::*;

  seq_state_e       state_q, state_d;
  op_e              op_q;
  logic [Q_W-1:0]   opnd_q;
  logic [Q_W-1:0]   res_q;
  logic [Q_W-1:0]   top_q;
  logic [LVL_W-1:0] level_q;
  logic [4:0]       push_cnt_q;
  logic [4:0]       max_q;

  logic             out_valid_q;
  logic [Q_W-1:0]   out_top_q;
  status_e          out_status_q;
  logic [4:0]       out_depth_q;

  logic             commit;
  logic             in_bin;
  logic [LVL_W-1:0] lvl_m2;
  logic [LVL_W-1:0] lvl_n;
  logic [4:0]       push_n;
  logic [Q_W-1:0]   top_n;
  status_e          st_n;
  logic             wr_en;
  logic [IDX_W-1:0] waddr;
  logic [Q_W-1:0]   wdata;
  logic             mem_we;
  logic [Q_W-1:0]   rdata;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  assign lvl_m2 = level_q - LVL_W'(2);
  assign in_bin = (op_i == OP_ADD) || (op_i == OP_SUB) || (op_i == OP_MUL) ||
                  (op_i == OP_DIV);

  // Sequencer
  always_comb begin
    state_d       = state_q;
    in_ready_o    = (state_q == S_IDLE);
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    commit        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_bin && level_q >= LVL_W'(2)) state_d = S_LOAD;
          else state_d = S_DONE;
        end
      end
      S_LOAD: begin
        // left operand is in the read register now; skip the unit on divide by zero
        if (op_q == OP_DIV && top_q == '0) begin
          state_d = S_DONE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: if (alu_rsp.done) state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Stack update for the command in hand
  always_comb begin
    lvl_n  = level_q;
    push_n = push_cnt_q;
    top_n  = top_q;
    st_n   = ST_OK;
    wr_en  = 1'b0;
    waddr  = level_q[IDX_W-1:0];
    wdata  = opnd_q;
    unique case (op_q)
      OP_PUSH: begin
        if (push_cnt_q >= max_q || level_q >= LVL_W'(STACK_DEPTH)) begin
          st_n = ST_MANY;
        end else begin
          wr_en  = 1'b1;
          lvl_n  = level_q + LVL_W'(1);
          push_n = push_cnt_q + 5'd1;
          top_n  = opnd_q;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (level_q < LVL_W'(2)) begin
          st_n = ST_UNDER;
        end else if (op_q == OP_DIV && top_q == '0) begin
          st_n = ST_DIVZ;
        end else begin
          wr_en = 1'b1;
          waddr = lvl_m2[IDX_W-1:0];
          wdata = res_q;
          lvl_n = level_q - LVL_W'(1);
          top_n = res_q;
        end
      end
      OP_READ: begin
        if (level_q == '0) st_n = ST_UNDER;
        else if (level_q > LVL_W'(1)) st_n = ST_LEFT;
      end
      OP_CLEAR: begin
        lvl_n  = '0;
        push_n = '0;
      end
      default: ;
    endcase
  end

  assign mem_we = commit && wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      push_cnt_q  <= '0;
      max_q       <= MAX_PUSH_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (commit) begin
        level_q     <= lvl_n;
        push_cnt_q  <= push_n;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_e'(op_i);
      opnd_q <= operand_i;
    end
    if (alu_rsp.done) res_q <= alu_rsp.res;
    if (commit) begin
      top_q        <= top_n;
      out_top_q    <= (lvl_n != '0) ? top_n : '0;
      out_status_q <= st_n;
      out_depth_q  <= 5'(lvl_n);
    end
  end

  rpn_stack_mem #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(Q_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(lvl_m2[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  rpn_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (rdata),
    .b_i   (top_q),
    .rsp_o (alu_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign status_o    = out_status_q;
  assign depth_o     = out_depth_q;

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");
  a_write_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_DONE)
    else $error("stack write outside commit");
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == OP_PUSH && st_n == ST_OK) |=> level_q == $past(level_q) + LVL_W'(1))
    else $error("accepted push did not grow the stack");
  a_alu_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> level_q >= LVL_W'(2))
    else $error("arithmetic started without two operands");
`endif

endmodule

### hw/rtl/rpn_stack_mem.sv
module rpn_stack_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rpn_alu.sv
module rpn_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rpn_pkg::alu_req_t       req_i,
  input  logic [rpn_pkg::Q_W-1:0] a_i,
  input  logic [rpn_pkg::Q_W-1:0] b_i,
  output rpn_pkg::alu_rsp_t       rsp_o
);
  import rpn_pkg::*;

  alu_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [Q_W-1:0]   hi_q;
  logic [DVD_W-1:0] lo_q;
  logic [Q_W-1:0]   ma_q, mb_q;
  logic             neg_q;
  op_e              op_q;
  logic [Q_W-1:0]   res_q;

  logic [Q_W-1:0]   ma, mb;
  logic [Q_W:0]     add_x, add_y;
  logic             add_sub;
  logic [Q_W+1:0]   add_sum;
  logic             div_ge;
  logic [Q_W:0]     sum_as;
  logic [Q_W-1:0]   sat_as;
  logic [2*Q_W-1:0] prod, prod_rnd;
  logic             prod_neg;
  logic [Q_W-1:0]   fin_res;

  assign ma = a_i[Q_W-1] ? Q_W'(0) - a_i : a_i;
  assign mb = b_i[Q_W-1] ? Q_W'(0) - b_i : b_i;

  // Saturating add and subtract finish in the start cycle
  always_comb begin
    if (req_i.op == OP_SUB) sum_as = {a_i[Q_W-1], a_i} - {b_i[Q_W-1], b_i};
    else sum_as = {a_i[Q_W-1], a_i} + {b_i[Q_W-1], b_i};
    if (sum_as[Q_W] != sum_as[Q_W-1]) sat_as = sum_as[Q_W] ? Q_MIN : Q_MAX;
    else sat_as = sum_as[Q_W-1:0];
  end

  // Shared adder: shift-add multiply step or restoring divide step
  always_comb begin
    if (state_q == A_DIV) begin
      add_x   = {hi_q, lo_q[DVD_W-1]};
      add_y   = {1'b0, mb_q};
      add_sub = 1'b1;
    end else begin
      add_x   = {1'b0, hi_q};
      add_y   = lo_q[0] ? {1'b0, ma_q} : '0;
      add_sub = 1'b0;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y} + (Q_W+2)'(add_sub);
  end

  assign div_ge = add_sum[Q_W+1];

  // Floor rounding of the product: round the magnitude up when negative
  always_comb begin
    prod     = {hi_q, lo_q[Q_W-1:0]};
    prod_neg = neg_q && (prod != '0);
    prod_rnd = prod_neg ? prod + (2*Q_W)'(16'hFFFF) : prod;
    unique case (op_q)
      OP_MUL:  fin_res = sat_mag(prod_rnd[2*Q_W-1:FRAC_W], prod_neg);
      OP_DIV:  fin_res = sat_mag(lo_q, neg_q);
      default: fin_res = res_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          priority case (req_i.op)
            OP_MUL:  state_d = A_MUL;
            OP_DIV:  state_d = A_DIV;
            default: state_d = A_FIN;
          endcase
        end
      end
      A_MUL:   if (cnt_q == MUL_LAST) state_d = A_FIN;
      A_DIV:   if (cnt_q == DIV_LAST) state_d = A_FIN;
      A_FIN:   state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == A_IDLE) cnt_q <= '0;
      else cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_q  <= req_i.op;
          ma_q  <= ma;
          mb_q  <= mb;
          neg_q <= a_i[Q_W-1] ^ b_i[Q_W-1];
          hi_q  <= '0;
          res_q <= sat_as;
          if (req_i.op == OP_DIV) lo_q <= {ma, FRAC_W'(0)};
          else lo_q <= {FRAC_W'(0), mb};
        end
      end
      A_MUL: begin
        hi_q <= add_sum[Q_W:1];
        lo_q <= {FRAC_W'(0), add_sum[0], lo_q[Q_W-1:1]};
      end
      A_DIV: begin
        hi_q <= div_ge ? add_sum[Q_W-1:0] : add_x[Q_W-1:0];
        lo_q <= {lo_q[DVD_W-2:0], div_ge};
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == A_FIN);
  assign rsp_o.res  = fin_res;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == A_IDLE)
    else $error("alu start while busy");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_DIV |-> cnt_q <= DIV_LAST)
    else $error("divide step count overrun");
  a_mul_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_MUL |-> cnt_q <= MUL_LAST)
    else $error("multiply step count overrun");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done)
    else $error("done held longer than one cycle");
`endif

endmodule
